### hdl/mrst_pkg.sv
package mrst_pkg;

   // Frame and report geometry
   localparam int FRAME_BYTES = 3;
   localparam int DELTA_WIDTH = 12;

   // Width of the tick delay counter
   localparam int WAIT_WIDTH = 17;

   // Axis saturation limits
   localparam int SAT_MAX = 127;
   localparam int SAT_MIN = -128;

   // Low status bits come straight from the buttons
   localparam logic [7:0] BUTTON_MASK = 8'h0F;

   // Configuration register indexes
   localparam logic [1:0] REG_BIT_TICKS = 2'd0;
   localparam logic [1:0] REG_FRAME_GAP = 2'd1;
   localparam logic [1:0] REG_SECONDARY = 2'd2;

   // Register reset values
   localparam logic [15:0] BIT_TICKS_RESET = 16'd208;
   localparam logic [15:0] FRAME_GAP_RESET = 16'd20000;

   // Transmit sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LOAD,
      PH_START,
      PH_DATA,
      PH_STOP,
      PH_END
   } phase_type;

   // Build {Y, X, status} from one movement report; Y is negated
   function automatic logic [23:0] make_report(
      input logic [DELTA_WIDTH-1:0] x_raw,
      input logic [DELTA_WIDTH-1:0] y_raw,
      input logic [3:0]             btn
   );
      logic signed [DELTA_WIDTH:0] xs;
      logic signed [DELTA_WIDTH:0] ys;
      logic signed [DELTA_WIDTH:0] sat_hi;
      logic signed [DELTA_WIDTH:0] sat_lo;
      logic [7:0]                  st;
      logic [7:0]                  xb;
      logic [7:0]                  yb;
      sat_hi = (DELTA_WIDTH+1)'(SAT_MAX);
      sat_lo = (DELTA_WIDTH+1)'(SAT_MIN);
      xs = $signed({x_raw[DELTA_WIDTH-1], x_raw});
      ys = -$signed({y_raw[DELTA_WIDTH-1], y_raw});
      st = {3'b000, x_raw[8], 4'b0000} | ({4'b0000, btn} & BUTTON_MASK);
      xb = xs[7:0];
      yb = ys[7:0];
      if (xs > sat_hi) begin
         xb = sat_hi[7:0];
         st[4] = 1'b1;
      end
      if (xs < sat_lo) begin
         xb = sat_lo[7:0];
         st[5] = 1'b1;
      end
      if (ys > sat_hi) begin
         yb = sat_hi[7:0];
         st[6] = 1'b1;
      end
      if (ys < sat_lo) begin
         yb = sat_lo[7:0];
         st[7] = 1'b1;
      end
      return {yb, xb, st};
   endfunction

endpackage

### hdl/mouse_report_serial_transmitter.sv
// Latency: the response to a request is valid in the cycle after the request is taken.
// Throughput: one request per cycle unless the response is held; each request updates the
// sequencer state once, and the output register frees its slot in the same cycle it is read.
// Serial timing is counted in tick requests, not clock cycles.
// Reset (synchronous, active high): sequencer idle, line high, no pending report,
// bit_ticks 208, frame_gap_ticks 20000, primary mode.
module mouse_report_serial_transmitter
   import mrst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // ctrl_line, x_delta[11:0], y_delta[11:0], buttons[3:0], pad
   input  logic        req_tuser,  // cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // data_line, sending, frame_started, pad
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Request fields
   logic                   req_cmd;
   logic                   req_ctrl;
   logic [DELTA_WIDTH-1:0] req_x;
   logic [DELTA_WIDTH-1:0] req_y;
   logic [3:0]             req_buttons;
   logic                   req_fire;

   assign req_cmd     = req_tuser;
   assign req_ctrl    = req_tdata[0];
   assign req_x       = req_tdata[DELTA_WIDTH:1];
   assign req_y       = req_tdata[2*DELTA_WIDTH:DELTA_WIDTH+1];
   assign req_buttons = req_tdata[2*DELTA_WIDTH+4:2*DELTA_WIDTH+1];

   // Configuration registers
   logic [15:0] bit_ticks_ff;
   logic [15:0] frame_gap_ff;
   logic        secondary_ff;

   // Sequencer state
   phase_type             phase_ff, phase_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0]            shift_ff, shift_in;
   logic [3:0]            bits_left_ff, bits_left_in;
   logic [1:0]            bytes_left_ff, bytes_left_in;
   logic [23:0]           frame_ff, frame_in;
   logic [23:0]           pending_ff, pending_in;
   logic                  report_valid_ff, report_valid_in;
   logic                  seen_high_ff, seen_high_in;
   logic                  line_ff, line_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_data_ff;
   logic       started;

   // Tick decode
   logic tick;
   logic advance;
   logic seen_now;
   logic frame_go;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign tick     = req_fire && !req_cmd;
   assign advance  = tick && (((phase_ff == PH_IDLE) && !secondary_ff) ||
                              (wait_ff <= WAIT_WIDTH'(1)));
   assign seen_now = seen_high_ff || (!secondary_ff && req_ctrl);
   assign frame_go = secondary_ff || (seen_now && !req_ctrl);

   // Configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
         frame_gap_ff <= FRAME_GAP_RESET;
         secondary_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_BIT_TICKS: bit_ticks_ff <= csr_data;
            REG_FRAME_GAP: frame_gap_ff <= csr_data;
            REG_SECONDARY: secondary_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            PH_IDLE:  if (frame_go) phase_in = PH_LOAD;
            PH_LOAD:  phase_in = PH_START;
            PH_START: phase_in = PH_DATA;
            PH_DATA:  if (bits_left_ff == 4'd0) phase_in = PH_STOP;
            PH_STOP:  phase_in = PH_END;
            PH_END:   phase_in = (bytes_left_ff != 2'd0) ? PH_LOAD : PH_IDLE;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // Datapath and outputs for each phase
   always_comb begin
      wait_in         = wait_ff;
      shift_in        = shift_ff;
      bits_left_in    = bits_left_ff;
      bytes_left_in   = bytes_left_ff;
      frame_in        = frame_ff;
      pending_in      = pending_ff;
      report_valid_in = report_valid_ff;
      seen_high_in    = seen_high_ff;
      line_in         = line_ff;
      started         = 1'b0;
      if (req_fire && req_cmd) begin
         pending_in      = make_report(req_x, req_y, req_buttons);
         report_valid_in = 1'b1;
      end else if (advance) begin
         wait_in = '0;
         unique case (phase_ff)
            PH_IDLE: begin
               seen_high_in = seen_now;
               if (frame_go) begin
                  frame_in        = report_valid_ff ? pending_ff : 24'd0;
                  report_valid_in = 1'b0;
                  bytes_left_in   = 2'(FRAME_BYTES);
                  seen_high_in    = 1'b0;
                  started         = 1'b1;
               end
            end
            PH_LOAD: begin
               line_in       = 1'b1;
               shift_in      = frame_ff[7:0];
               frame_in      = {8'd0, frame_ff[23:8]};
               bits_left_in  = 4'd8;
               bytes_left_in = bytes_left_ff - 2'd1;
            end
            PH_START: begin
               line_in = 1'b0;
               wait_in = {1'b0, bit_ticks_ff};
            end
            PH_DATA: begin
               if (bits_left_ff != 4'd0) begin
                  line_in      = shift_ff[0];
                  shift_in     = {1'b0, shift_ff[7:1]};
                  wait_in      = {1'b0, bit_ticks_ff};
                  bits_left_in = bits_left_ff - 4'd1;
               end
            end
            PH_STOP: begin
               // two stop bits
               line_in = 1'b1;
               wait_in = {bit_ticks_ff, 1'b0};
            end
            PH_END: begin
               if (bytes_left_ff == 2'd0) wait_in = {1'b0, frame_gap_ff};
            end
            default: ;
         endcase
      end else if (tick) begin
         wait_in = wait_ff - WAIT_WIDTH'(1);
      end
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         wait_ff         <= '0;
         shift_ff        <= '0;
         bits_left_ff    <= '0;
         bytes_left_ff   <= '0;
         frame_ff        <= '0;
         pending_ff      <= '0;
         report_valid_ff <= 1'b0;
         seen_high_ff    <= 1'b0;
         line_ff         <= 1'b1;
      end else begin
         phase_ff        <= phase_in;
         wait_ff         <= wait_in;
         shift_ff        <= shift_in;
         bits_left_ff    <= bits_left_in;
         bytes_left_ff   <= bytes_left_in;
         frame_ff        <= frame_in;
         pending_ff      <= pending_in;
         report_valid_ff <= report_valid_in;
         seen_high_ff    <= seen_high_in;
         line_ff         <= line_in;
      end
   end

   // Response register
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {started, (phase_in != PH_IDLE), line_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   // Checks
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= 4'd8)
      else $error("bit counter out of range");

   a_load_no_wait: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LOAD) |-> (wait_ff == '0))
      else $error("load phase entered with a pending delay");

   a_load_line_high: assert property (@(posedge clock) disable iff (reset)
      (tick && (phase_ff == PH_LOAD)) |=> line_ff)
      else $error("line not idle high after byte load");

   a_start_sending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[2]) |-> rsp_data_ff[1])
      else $error("frame start reported while not sending");

endmodule

### tb/mouse_report_serial_transmitter_tb.sv
module mouse_report_serial_transmitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrst_pkg::*;

   // Response fields, data_line in bit 0
   typedef struct packed {
      logic frame_started;
      logic sending;
      logic data_line;
   } line_state_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // ctrl_line, x_delta[11:0], y_delta[11:0], buttons[3:0], pad
   logic        req_tuser;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // data_line, sending, frame_started, pad
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   mouse_report_serial_transmitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Run control and bookkeeping
   line_state_type expected_lines[$];
   int             error_count   = 0;
   int             rsp_count     = 0;
   int             tx_idle_pct   = 38;
   int             rx_idle_pct   = 38;
   int             hold_left     = 0;
   logic           ctrl_level    = 1'b1;

   // Predictor: configuration
   logic [15:0] cfg_bit_ticks;
   logic [15:0] cfg_gap_ticks;
   logic        cfg_secondary;

   // Predictor: sequencer state
   phase_type   tx_phase;
   logic [16:0] tick_wait;
   logic [7:0]  shift_byte;
   logic [3:0]  bits_to_send;
   logic [1:0]  bytes_to_send;
   logic [23:0] frame_data;
   logic [23:0] queued_report;
   logic        report_queued;
   logic        ctrl_armed;
   logic        line_out;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic reset_model();
      cfg_bit_ticks = BIT_TICKS_RESET;
      cfg_gap_ticks = FRAME_GAP_RESET;
      cfg_secondary = 1'b0;
      tx_phase      = PH_IDLE;
      tick_wait     = '0;
      shift_byte    = '0;
      bits_to_send  = '0;
      bytes_to_send = '0;
      frame_data    = '0;
      queued_report = '0;
      report_queued = 1'b0;
      ctrl_armed    = 1'b0;
      line_out      = 1'b1;
   endtask

   // Status, X and Y bytes of one report; Y flips sign, both axes clamp
   function automatic logic [23:0] encode_report(input logic [11:0] xd, input logic [11:0] yd,
                                                 input logic [3:0] btn);
      int         x;
      int         y;
      logic [7:0] st;
      x  = $signed(xd);
      y  = -int'($signed(yd));
      st = {3'b000, xd[8], btn};
      if (x > 127) begin
         x     = 127;
         st[4] = 1'b1;
      end
      if (x < -128) begin
         x     = -128;
         st[5] = 1'b1;
      end
      if (y > 127) begin
         y     = 127;
         st[6] = 1'b1;
      end
      if (y < -128) begin
         y     = -128;
         st[7] = 1'b1;
      end
      return {y[7:0], x[7:0], st};
   endfunction

   // One action of the transmit sequencer
   task automatic step_sequencer(input logic ctrl, output logic started);
      logic [16:0] delay;
      delay   = '0;
      started = 1'b0;
      case (tx_phase)
         PH_IDLE: begin
            if (!cfg_secondary && ctrl) ctrl_armed = 1'b1;
            if (cfg_secondary || (ctrl_armed && !ctrl)) begin
               frame_data    = report_queued ? queued_report : 24'd0;
               report_queued = 1'b0;
               bytes_to_send = 2'(FRAME_BYTES);
               tx_phase      = PH_LOAD;
               ctrl_armed    = 1'b0;
               started       = 1'b1;
            end
         end
         PH_LOAD: begin
            line_out      = 1'b1;
            shift_byte    = frame_data[7:0];
            frame_data    = frame_data >> 8;
            bits_to_send  = 4'd8;
            bytes_to_send = bytes_to_send - 2'd1;
            tx_phase      = PH_START;
         end
         PH_START: begin
            line_out = 1'b0;
            delay    = {1'b0, cfg_bit_ticks};
            tx_phase = PH_DATA;
         end
         PH_DATA: begin
            if (bits_to_send != 0) begin
               line_out     = shift_byte[0];
               shift_byte   = shift_byte >> 1;
               delay        = {1'b0, cfg_bit_ticks};
               bits_to_send = bits_to_send - 4'd1;
            end else begin
               tx_phase = PH_STOP;
            end
         end
         PH_STOP: begin
            line_out = 1'b1;
            delay    = {cfg_bit_ticks, 1'b0};
            tx_phase = PH_END;
         end
         default: begin
            if (bytes_to_send != 0) begin
               tx_phase = PH_LOAD;
            end else begin
               delay    = {1'b0, cfg_gap_ticks};
               tx_phase = PH_IDLE;
            end
         end
      endcase
      tick_wait = delay;
   endtask

   // Expected response to one request
   task automatic predict_line(input logic cmd, input logic ctrl, input logic [11:0] xd,
                               input logic [11:0] yd, input logic [3:0] btn,
                               output line_state_type r);
      logic started;
      started = 1'b0;
      if (cmd) begin
         queued_report = encode_report(xd, yd, btn);
         report_queued = 1'b1;
      end else if ((tx_phase == PH_IDLE && !cfg_secondary) || tick_wait <= 1) begin
         tick_wait = '0;
         step_sequencer(ctrl, started);
      end else begin
         tick_wait = tick_wait - 17'd1;
      end
      r.data_line     = line_out;
      r.sending       = (tx_phase != PH_IDLE);
      r.frame_started = started;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 40)
         $display("MISMATCH %s at response %0d: got %0d, want %0d", what, rsp_count, got, want);
      error_count++;
   endtask

   // Send one request; predict at acceptance, then maybe idle a little
   task automatic send_request(input logic cmd, input logic ctrl, input logic [11:0] xd,
                               input logic [11:0] yd, input logic [3:0] btn);
      line_state_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, btn, yd, xd, ctrl};
      do @(posedge clock); while (!req_tready);
      predict_line(cmd, ctrl, xd, yd, btn, r);
      expected_lines = {expected_lines, r};
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Register write, only with nothing in flight
   task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_BIT_TICKS: cfg_bit_ticks = val;
         REG_FRAME_GAP: cfg_gap_ticks = val;
         REG_SECONDARY: cfg_secondary = val[0];
         default: ;
      endcase
   endtask

   // Deltas biased toward the clamp edges
   function automatic logic [11:0] random_delta();
      int v;
      case ($urandom_range(9))
         0: v = $urandom_range(1) ? 2047 : -2048;
         1, 2, 3: v = int'($urandom_range(300)) - 150;
         default: v = $urandom;
      endcase
      return v[11:0];
   endfunction

   // Mostly ticks with a slowly toggling control line, some reports
   task automatic send_random_request();
      if ($urandom_range(99) < 12) begin
         send_request(1'b1, 1'($urandom_range(1)), random_delta(), random_delta(),
                      4'($urandom_range(15)));
      end else begin
         if ($urandom_range(11) == 0) ctrl_level = ~ctrl_level;
         send_request(1'b0, ctrl_level, 12'($urandom), 12'($urandom), 4'($urandom_range(15)));
      end
   endtask

   // Saturation corners, status bits and a frame with a report arriving mid-frame
   task automatic test_directed();
      send_request(1'b0, 1'b1, 12'h000, 12'h000, 4'h0);
      send_request(1'b0, 1'b0, 12'h000, 12'h000, 4'h0);   // falling edge starts a zero frame
      send_request(1'b0, 1'b0, 12'h000, 12'h000, 4'h0);
      send_request(1'b0, 1'b1, 12'h000, 12'h000, 4'h0);
      write_register(REG_BIT_TICKS, 16'd1);
      write_register(REG_FRAME_GAP, 16'd1);
      send_request(1'b1, 1'b0, 12'h7FF, 12'h800, 4'hF);   // both axes overflow
      send_request(1'b1, 1'b1, 12'h800, 12'h7FF, 4'h0);   // both axes underflow
      send_request(1'b1, 1'b0, 12'd127, 12'hF81, 4'h5);   // largest in range
      send_request(1'b1, 1'b0, 12'd128, 12'hF80, 4'hA);   // one past the top
      send_request(1'b1, 1'b0, 12'hF80, 12'd128, 4'h3);   // smallest in range
      send_request(1'b1, 1'b0, 12'hF7F, 12'd129, 4'hC);   // one past the bottom
      send_request(1'b1, 1'b0, 12'h100, 12'h000, 4'h0);
      send_request(1'b1, 1'b0, 12'hFFF, 12'h001, 4'h6);   // negative X in range sets bit 4
      for (int i = 0; i < 6; i++)
         send_request(1'b0, 1'b1, 12'h000, 12'h000, 4'h0);
      send_request(1'b0, 1'b0, 12'hFFF, 12'hFFF, 4'hF);   // falling control line, but the zero frame is still sending
      for (int i = 0; i < 4; i++)
         send_request(1'b0, 1'b0, 12'h000, 12'h000, 4'h0);
      send_request(1'b1, 1'b1, 12'd5, 12'hFFB, 4'h1);     // report during the frame
      for (int i = 0; i < 3; i++)
         send_request(1'b0, 1'b1, 12'h000, 12'h000, 4'h0);
   endtask

   // Random traffic over several settings, extremes included
   task automatic test_config_sweep();
      int unsigned sweep_bits[8] = '{1, 2, 0, 3, 65535, 1, 5, 1};
      int unsigned sweep_gap[8]  = '{1, 3, 0, 65535, 2, 4, 1, 2};
      int unsigned sweep_mode[8] = '{0, 1, 1, 1, 0, 0, 1, 0};
      int unsigned sweep_len[8]  = '{220, 220, 160, 150, 30, 220, 200, 220};
      for (int p = 0; p < 8; p++) begin
         write_register(REG_BIT_TICKS, 16'(sweep_bits[p]));
         write_register(REG_FRAME_GAP, 16'(sweep_gap[p]));
         write_register(REG_SECONDARY, 16'(sweep_mode[p]));
         for (int i = 0; i < sweep_len[p]; i++)
            send_random_request();
      end
   endtask

   // Receiver holds off long enough for the input to stall
   task automatic test_backpressure();
      write_register(REG_BIT_TICKS, 16'd2);
      write_register(REG_SECONDARY, 16'd0);
      hold_left = 300;
      for (int i = 0; i < 150; i++)
         send_random_request();
   endtask

   // Back-to-back traffic on both sides
   task automatic test_no_idle();
      write_register(REG_BIT_TICKS, 16'd1);
      write_register(REG_SECONDARY, 16'd1);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      for (int i = 0; i < 250; i++)
         send_random_request();
      tx_idle_pct = 38;
      rx_idle_pct = 38;
   endtask

   // Response side ready, with random stalls and the long hold
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Compare each response with the oldest expectation
   always @(posedge clock) begin : check_responses
      line_state_type got;
      line_state_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = line_state_type'(rsp_tdata[2:0]);
         if (expected_lines.size() == 0) begin
            report_mismatch("response with nothing expected", got, 0);
         end else begin
            want = expected_lines.pop_front();
            if (got.data_line !== want.data_line)
               report_mismatch("data_line", got.data_line, want.data_line);
            if (got.sending !== want.sending)
               report_mismatch("sending", got.sending, want.sending);
            if (got.frame_started !== want.frame_started)
               report_mismatch("frame_started", got.frame_started, want.frame_started);
         end
         rsp_count++;
      end
   end

   // Main sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_config_sweep();
      test_backpressure();
      test_no_idle();

      req_tvalid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_lines.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
